>>> rtl/fue_pkg.sv
// Shared types, constants and character helpers for the form-urlencoded encoder.
`default_nettype none
package fue_pkg;

  localparam int unsigned MAX_HELD_SPACES = 16;
  localparam int unsigned HELD_W          = $clog2(MAX_HELD_SPACES + 1);
  // longest expansion: all held spaces plus the six-character line break
  localparam int unsigned POS_W           = $clog2(MAX_HELD_SPACES + 6);

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPD   = 8'h44;

  typedef enum logic [2:0] {
    K_PLUS_ONLY,  // only the held '+' characters
    K_BARE_END,   // end marker with no character
    K_PLAIN,      // one literal character
    K_ESCAPE,     // %XY
    K_NEWLINE     // %0D%0A
  } cmd_kind_t;

  typedef struct packed {
    logic [HELD_W-1:0] plus_cnt;
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic              last;
  } cmd_t;

  function automatic logic must_escape(input logic [7:0] b);
    logic r;
    r = (b < CH_SPACE) || (b >= CH_DEL) ||
        (b >= 8'h21 && b <= 8'h2D) || (b == 8'h2F) ||
        (b >= 8'h3A && b <= 8'h40) || (b >= 8'h5B && b <= 8'h5E) ||
        (b == 8'h60) || (b >= 8'h7B && b <= 8'h7E);
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = CH_ZERO + {4'd0, n};
    else           r = CH_UPA + {4'd0, n} - 8'd10;
    return r;
  endfunction

  function automatic logic [7:0] newline_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0, 3'd3: r = CH_PCT;
      3'd1, 3'd4: r = CH_ZERO;
      3'd2:       r = CH_UPD;
      default:    r = CH_UPA;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kind_len(input cmd_kind_t k);
    logic [2:0] r;
    unique case (k)
      K_PLUS_ONLY: r = 3'd0;
      K_BARE_END:  r = 3'd1;
      K_PLAIN:     r = 3'd1;
      K_ESCAPE:    r = 3'd3;
      K_NEWLINE:   r = 3'd6;
      default:     r = 3'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fue_front.sv
// Front end: accepts raw bytes, tracks held spaces and issues expansion commands.
`default_nettype none
module fue_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          strip,
  input  wire logic          in_fire,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output fue_pkg::cmd_t      cmd,
  output logic               cmd_push
);
  import fue_pkg::*;

  logic [HELD_W-1:0] held;
  logic [HELD_W-1:0] held_next;

  always_comb begin
    cmd          = '0;
    cmd.data     = in_byte;
    cmd.last     = in_last;
    cmd.plus_cnt = held;
    cmd.kind     = K_PLAIN;
    cmd_push     = in_fire;
    held_next    = held;
    if (in_byte == CH_SPACE && strip) begin
      if (in_last) begin
        cmd.kind     = K_BARE_END;
        cmd.plus_cnt = '0;
        held_next    = '0;
      end else if (held >= HELD_W'(MAX_HELD_SPACES)) begin
        // counter full: oldest held space goes out now
        cmd.kind     = K_PLUS_ONLY;
        cmd.plus_cnt = HELD_W'(1);
      end else begin
        cmd_push     = 1'b0;
        held_next    = held + HELD_W'(1);
      end
    end else begin
      held_next = '0;
      if (in_byte == CH_LF) begin
        cmd.kind = K_NEWLINE;
      end else if (must_escape(in_byte)) begin
        cmd.kind = K_ESCAPE;
      end else if (in_byte == CH_SPACE) begin
        cmd.data = CH_PLUS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (in_fire) begin
      held <= held_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fue_queue.sv
// Short command queue between front and back end.
`default_nettype none
module fue_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  fue_pkg::cmd_t      push_cmd,
  input  wire logic          pop,
  output fue_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);
  import fue_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/fue_back.sv
// Back end: expands queued commands into output characters, one per cycle while the output is not stalled.
`default_nettype none
module fue_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  fue_pkg::cmd_t      head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_has,
  output logic               out_end
);
  import fue_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] idx;
  logic             load;
  logic             final_char;
  logic [7:0]       ch;
  logic             ch_has;

  assign load       = !empty && (!out_valid || out_ready);
  assign total      = POS_W'(head.plus_cnt) + POS_W'(kind_len(head.kind));
  assign final_char = (pos == total - POS_W'(1));
  assign pop        = load && final_char;
  assign idx        = pos - POS_W'(head.plus_cnt);
  assign pos_next   = final_char ? '0 : pos + POS_W'(1);

  always_comb begin
    ch     = CH_PLUS;
    ch_has = 1'b1;
    if (pos >= POS_W'(head.plus_cnt)) begin
      unique case (head.kind)
        K_BARE_END: begin
          ch     = '0;
          ch_has = 1'b0;
        end
        K_PLAIN:   ch = head.data;
        K_ESCAPE: begin
          if (idx == '0)               ch = CH_PCT;
          else if (idx == POS_W'(1))   ch = hex_digit(head.data[7:4]);
          else                         ch = hex_digit(head.data[3:0]);
        end
        K_NEWLINE: ch = newline_char(idx[2:0]);
        default:   ch = CH_PLUS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pos       <= pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= ch;
      out_has  <= ch_has;
      out_end  <= final_char && head.last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/form_url_encoder.sv
// Form-urlencoded encoder: one name or value byte stream in, encoded characters out.
// An accepted byte passes the command queue and the output register before its first character.
// Throughput: input taken every cycle while the four-entry command queue has room;
//   the back end emits one character per cycle unless the output stalls, so a byte costs 0 (a held space)
//   to 22 output characters (held '+' characters plus 1, 3 or 6), and that output port sets the rate.
// Reset (rst, synchronous): queue, held-space count and output valid cleared;
//   trailing-space stripping comes up enabled.
`default_nettype none
module form_url_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: strip_trailing_spaces
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  // raw string in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  // encoded characters out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tuser,   // [0] has_byte
  output logic             m_tlast    // end_of_string
);
  import fue_pkg::*;

  logic strip;
  logic in_fire;
  cmd_t push_cmd;
  logic push;
  cmd_t head;
  logic q_empty;
  logic q_full;
  logic pop;

  // The user must write the register only while idle; the block does not enforce this, so cfg_ready is always high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      strip <= cfg_data;
    end
  end

  // Front takes a byte whenever a queue slot is free; a held space needs none,
  // but keeping the rule uniform keeps s_tready off the output path.
  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  fue_front u_front (
    .clk      (clk),
    .rst      (rst),
    .strip    (strip),
    .in_fire  (in_fire),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .cmd      (push_cmd),
    .cmd_push (push)
  );

  fue_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end walks the head command one character per cycle, while the output is not
  // stalled, into the output register; the last character of a command pops it.
  fue_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_has   (m_tuser),
    .out_end   (m_tlast)
  );

endmodule
`default_nettype wire

>>> test/form_url_encoder_tb.sv
// Self-checking testbench for form_url_encoder: directed and random stream traffic against a predictor.
module form_url_encoder_tb;
  import fue_pkg::*;

  // One encoded character as it should appear on the master side.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eos;
  } enc_char_t;

  // Scoreboard: predicts the encoded characters of each accepted request
  // and checks them, in order, against what the block emits.
  class encoded_char_board;
    enc_char_t  expected_chars[$];
    logic [4:0] held_spaces;
    logic       strip;
    bit         esc_map[256];
    string      hex_chars;
    int         errors;

    function new();
      string punct;
      punct = "!\"#$%&'()*+,-/:;<=>?@[\\]^`{|}~";
      hex_chars = "0123456789ABCDEF";
      held_spaces = '0;
      strip = 1'b1;
      errors = 0;
      for (int i = 0; i < 256; i++) esc_map[i] = (i < 'h20) || (i >= 'h7F);
      for (int k = 0; k < punct.len(); k++) esc_map[punct[k]] = 1'b1;
    endfunction

    function void set_strip(logic v);
      strip = v;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // Work out the characters one raw byte turns into.
    function void encode_byte(logic [7:0] b, logic lst);
      logic [7:0] seq[$];
      if (b == CH_SPACE && strip) begin
        if (lst) begin
          // trailing run dropped, only the end marker remains
          held_spaces = '0;
          expected_chars.push_back('{ch: 8'h00, has: 1'b0, eos: 1'b1});
          return;
        end
        // counter full: the oldest held space goes out now, count stays put
        if (held_spaces >= MAX_HELD_SPACES)
          expected_chars.push_back('{ch: CH_PLUS, has: 1'b1, eos: 1'b0});
        else
          held_spaces = held_spaces + 5'd1;
        return;
      end
      repeat (held_spaces) seq.push_back(CH_PLUS);
      held_spaces = '0;
      if (b == CH_LF) begin
        seq.push_back(CH_PCT); seq.push_back("0"); seq.push_back("D");
        seq.push_back(CH_PCT); seq.push_back("0"); seq.push_back("A");
      end else if (esc_map[b]) begin
        seq.push_back(CH_PCT);
        seq.push_back(hex_chars[b[7:4]]);
        seq.push_back(hex_chars[b[3:0]]);
      end else if (b == CH_SPACE) begin
        seq.push_back(CH_PLUS);
      end else begin
        seq.push_back(b);
      end
      foreach (seq[i])
        expected_chars.push_back('{ch: seq[i], has: 1'b1,
                                   eos: lst && (i == seq.size() - 1)});
    endfunction

    task report(string msg);
      $display("encoder error at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_char(logic [7:0] d, logic has, logic eos);
      enc_char_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %02h has=%0b end=%0b", d, has, eos));
        return;
      end
      want = expected_chars.pop_front();
      if (d !== want.ch)
        report($sformatf("out_byte %02h, want %02h", d, want.ch));
      if (has !== want.has)
        report($sformatf("has_byte %0b, want %0b", has, want.has));
      if (eos !== want.eos)
        report($sformatf("end_of_string %0b, want %0b", eos, want.eos));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] data_byte
  logic       s_tlast;   // last_byte
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_byte
  logic       m_tuser;   // [0] has_byte
  logic       m_tlast;   // end_of_string

  // Phase-level switches that turn idling off on one side for a stretch.
  bit rush_tx;
  bit rush_rx;
  int items_sent;

  encoded_char_board board = new();

  form_url_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Output side: every accepted character is checked at the edge it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_char(m_tdata, m_tuser, m_tlast);
  end

  // Receiver: draws a random stall before each character, unless
  // the current phase runs it flat out.
  initial begin : rx_side
    int stall;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = rush_rx ? 0 : $urandom_range(0, 10);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Safety net against a hung handshake; far above the slowest legal run.
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One raw byte request. Valid stays high across back-to-back requests;
  // a gap lowers it at each falling edge of the gap.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = rush_tx ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    board.encode_byte(b, lst);
    items_sent++;
  endtask

  // Byte mix weighted toward spaces and line feeds, the costly cases.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)      return CH_SPACE;
    else if (r < 43) return CH_LF;
    else if (r < 70) return 8'($urandom_range('h21, 'h7E));
    else             return 8'($urandom_range(1, 255));
  endfunction

  // A whole string; now and then a long space run to hit the full counter.
  task automatic send_string();
    logic [7:0] bytes_q[$];
    int len;
    len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0)
        repeat ($urandom_range(14, 20)) bytes_q.push_back(CH_SPACE);
      else
        bytes_q.push_back(pick_byte());
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // Sender stops until every predicted character is out, then lets the
  // pipeline settle (a held-space byte leaves nothing to wait on).
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_strip(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_strip(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ph;
    int phase_start;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    rush_tx   = 1'b0;
    rush_rx   = 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: escape extremes, line break, plain char, end of string.
    write_strip(1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("z", 1'b1);
    // Seventeen spaces overflow the counter, so one '+' goes out; a space as last byte then
    // drops the rest of the run and leaves a bare end marker.
    repeat (17) send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SPACE, 1'b1);
    // Spaces held when stripping goes off come out ahead of the next byte.
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    wait_drained();
    write_strip(1'b0);
    send_byte("~", 1'b1);
    wait_drained();

    // Random phases; each starts with a register write on an idle block and
    // may end mid-string with spaces still held.
    for (ph = 0; ph < 6; ph++) begin
      write_strip((ph % 3 == 2) ? 1'($urandom_range(0, 1)) : ((ph % 2) == 0));
      rush_tx = ($urandom_range(0, 3) == 0);
      rush_rx = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < 50) send_string();
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) send_byte(CH_SPACE, 1'b0);
      wait_drained();
    end

    if (board.errors == 0 && board.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
